// ----- src/mcl_pkg.sv -----
// Shared types and constants of the DC motor command latch.
// Depends on nothing; used by every module of the block.
package mcl_pkg;

    localparam int unsigned MOTORS      = 4;
    localparam int unsigned LATCH_W     = 8;
    localparam int unsigned DUTY_W      = 8;
    localparam int unsigned SPEED_W     = 11;
    localparam int unsigned INDEX_W     = 3;
    localparam int unsigned CH_W        = 2;
    localparam int unsigned BITPOS_W    = 3;
    localparam int unsigned BITCNT_W    = 3;

    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 8'd255;
    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 11'sd255;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    localparam logic [BITPOS_W-1:0] BRIDGE_A_POS [MOTORS] = '{3'd2, 3'd1, 3'd5, 3'd0};
    localparam logic [BITPOS_W-1:0] BRIDGE_B_POS [MOTORS] = '{3'd3, 3'd4, 3'd7, 3'd6};

    typedef struct packed {
        logic              shift;
        logic [CH_W-1:0]   ch;
        logic [DUTY_W-1:0] duty;
        logic [LATCH_W-1:0] latch;
    } t_load;

    typedef struct packed {
        logic              motor_ok;
        logic              changed;
        t_dir              dir;
        t_load             load;
    } t_cmd;

    function automatic logic [LATCH_W-1:0] bit_mask(input logic [BITPOS_W-1:0] pos);
        logic [LATCH_W-1:0] m;
        m = '0;
        m[pos] = 1'b1;
        return m;
    endfunction

endpackage

// ----- src/mcl_cmd.sv -----
// Command decode: clamp, deadband duty, direction and latch byte update.
// Depends on mcl_pkg.
module mcl_cmd (
    input  logic [mcl_pkg::INDEX_W-1:0]        i_motor_index,
    input  logic signed [mcl_pkg::SPEED_W-1:0] i_speed,
    input  logic [mcl_pkg::DUTY_W-1:0]         i_dead_band,
    input  mcl_pkg::t_dir                      i_last_dir [mcl_pkg::MOTORS],
    input  logic [mcl_pkg::LATCH_W-1:0]        i_latch,
    output mcl_pkg::t_cmd                      o_cmd
);
    import mcl_pkg::*;

    logic signed [SPEED_W-1:0] w_clamped;
    logic [SPEED_W-1:0]        w_abs;
    logic [DUTY_W-1:0]         w_mag;
    logic [DUTY_W:0]           w_sum;
    logic [CH_W-1:0]           w_ch;
    logic [LATCH_W-1:0]        w_amask;
    logic [LATCH_W-1:0]        w_bmask;
    t_dir                      w_dir;

    always_comb begin
        o_cmd = '0;
        w_ch = CH_W'(i_motor_index - INDEX_W'(1));
        o_cmd.motor_ok = (i_motor_index >= INDEX_W'(1)) && (i_motor_index <= INDEX_W'(MOTORS));

        if (i_speed > SPEED_LIMIT) begin
            w_clamped = SPEED_LIMIT;
        end else if (i_speed < -SPEED_LIMIT) begin
            w_clamped = -SPEED_LIMIT;
        end else begin
            w_clamped = i_speed;
        end
        w_abs = w_clamped[SPEED_W-1] ? SPEED_W'(-w_clamped) : SPEED_W'(w_clamped);
        w_mag = w_abs[DUTY_W-1:0];
        w_sum = {1'b0, w_mag};
        if (w_mag < i_dead_band) begin
            w_sum = {1'b0, w_mag} + {1'b0, i_dead_band};
        end

        if (w_clamped[SPEED_W-1]) begin
            w_dir = DIR_BACK;
        end else if (w_clamped != '0) begin
            w_dir = DIR_FWD;
        end else begin
            w_dir = DIR_STOP;
        end

        w_amask = bit_mask(BRIDGE_A_POS[w_ch]);
        w_bmask = bit_mask(BRIDGE_B_POS[w_ch]);

        o_cmd.dir        = w_dir;
        o_cmd.changed    = (w_dir != i_last_dir[w_ch]);
        o_cmd.load.shift = o_cmd.changed;
        o_cmd.load.ch    = w_ch;
        o_cmd.load.duty  = w_sum[DUTY_W] ? DUTY_MAX : w_sum[DUTY_W-1:0];
        unique case (w_dir)
            DIR_FWD:  o_cmd.load.latch = (i_latch | w_amask) & ~w_bmask;
            DIR_BACK: o_cmd.load.latch = (i_latch & ~w_amask) | w_bmask;
            default:  o_cmd.load.latch = i_latch & ~(w_amask | w_bmask);
        endcase
        if (!o_cmd.changed) begin
            o_cmd.load.latch = i_latch;
        end
    end

endmodule

// ----- src/mcl_shift.sv -----
// Result register and serialiser: one duty-only transaction or eight latch bits.
// Depends on mcl_pkg.
module mcl_shift (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load_en,
    input  mcl_pkg::t_load              i_load,
    input  logic                        i_out_stall,
    output logic                        o_free,
    output logic                        o_out_valid,
    output logic [mcl_pkg::CH_W-1:0]    o_pwm_channel,
    output logic [mcl_pkg::DUTY_W-1:0]  o_duty,
    output logic                        o_bit_valid,
    output logic                        o_serial_bit,
    output logic                        o_last
);
    import mcl_pkg::*;

    logic                 r_valid;
    logic [BITCNT_W-1:0]  r_left;
    logic                 r_bit_valid;
    logic [LATCH_W-1:0]   r_byte;
    logic [CH_W-1:0]      r_ch;
    logic [DUTY_W-1:0]    r_duty;
    logic                 w_take;

    assign w_take  = r_valid && !i_out_stall;
    assign o_last  = (r_left == '0);
    assign o_free  = !r_valid || (w_take && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (o_free) begin
            r_valid <= i_load_en;
            r_left  <= i_load.shift ? BITCNT_W'(LATCH_W - 1) : '0;
        end else if (w_take) begin
            r_left  <= r_left - BITCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load_en) begin
            r_bit_valid <= i_load.shift;
            r_byte      <= i_load.shift ? i_load.latch : '0;
            r_ch        <= i_load.ch;
            r_duty      <= i_load.duty;
        end else if (w_take) begin
            r_byte <= {r_byte[LATCH_W-2:0], 1'b0};
        end
    end

    assign o_out_valid   = r_valid;
    assign o_pwm_channel = r_ch;
    assign o_duty        = r_duty;
    assign o_bit_valid   = r_bit_valid;
    assign o_serial_bit  = r_byte[LATCH_W-1];

endmodule

// ----- src/dc_motor_command_latch.sv -----
// Top level of the DC motor command latch: input register, motor state, serialiser.
// Depends on mcl_pkg, mcl_cmd and mcl_shift.
//
// Input channel: i_in_valid with i_motor_index and i_speed; o_in_stall back.
// A transaction is taken when valid is high and stall is low. It lands in an
// input register, is decoded from it combinationally and loaded into the
// result register when the serialiser is free, from which it is offered.
// Output channel: o_out_valid with the result fields; i_out_stall back.
// An unchanged direction gives one result (o_bit_valid low, o_last high):
// one input per cycle is sustained while the receiver does not stall. A
// direction change gives eight results, latch bit 7 first, o_last on the
// eighth; the next command waits until the last bit is taken. Motor numbers
// outside 1 to 4 are dropped. While the receiver stalls, the result holds,
// one further input is held in the input register, then o_in_stall rises.
// Reset (synchronous, active low) clears dead band, latch byte and all motor
// directions to stopped, and empties both registers; no clearing pass.
// i_cfg_we writes i_cfg_data into the dead band; write only while idle.
module dc_motor_command_latch (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mcl_pkg::DUTY_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mcl_pkg::INDEX_W-1:0]        i_motor_index,
    input  logic signed [mcl_pkg::SPEED_W-1:0] i_speed,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mcl_pkg::CH_W-1:0]           o_pwm_channel,
    output logic [mcl_pkg::DUTY_W-1:0]         o_duty,
    output logic                               o_bit_valid,
    output logic                               o_serial_bit,
    output logic                               o_last
);
    import mcl_pkg::*;

    logic                       r_in_valid;
    logic [INDEX_W-1:0]         r_motor_index;
    logic signed [SPEED_W-1:0]  r_speed;
    logic [DUTY_W-1:0]          r_dead_band;
    logic [LATCH_W-1:0]         r_latch;
    t_dir                       r_last_dir [MOTORS];
    t_cmd                       w_cmd;
    logic                       w_free;
    logic                       w_load;
    logic                       w_consume;

    mcl_cmd u_cmd (
        .i_motor_index (r_motor_index),
        .i_speed       (r_speed),
        .i_dead_band   (r_dead_band),
        .i_last_dir    (r_last_dir),
        .i_latch       (r_latch),
        .o_cmd         (w_cmd)
    );

    assign w_load     = r_in_valid && w_cmd.motor_ok && w_free;
    assign w_consume  = r_in_valid && (!w_cmd.motor_ok || w_free);
    assign o_in_stall = r_in_valid && !w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_dead_band <= '0;
            r_latch     <= '0;
            for (int i = 0; i < MOTORS; i++) begin
                r_last_dir[i] <= DIR_STOP;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                r_dead_band <= i_cfg_data;
            end
            if (w_load && w_cmd.changed) begin
                r_latch                    <= w_cmd.load.latch;
                r_last_dir[w_cmd.load.ch]  <= w_cmd.dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_motor_index <= i_motor_index;
            r_speed       <= i_speed;
        end
    end

    mcl_shift u_shift (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_en     (w_load),
        .i_load        (w_cmd.load),
        .i_out_stall   (i_out_stall),
        .o_free        (w_free),
        .o_out_valid   (o_out_valid),
        .o_pwm_channel (o_pwm_channel),
        .o_duty        (o_duty),
        .o_bit_valid   (o_bit_valid),
        .o_serial_bit  (o_serial_bit),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid && o_bit_valid)
        else $error("latch bit burst broken before its last bit");

    a_duty_only_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bit_valid |-> o_last)
        else $error("duty-only transaction not marked last");

    a_burst_fields_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last
        |=> $stable(o_pwm_channel) && $stable(o_duty))
        else $error("channel or duty changed inside a burst");

    a_held_input_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_cmd.motor_ok && !w_free |=> r_in_valid && $stable(r_speed))
        else $error("pending command lost while serialiser busy");
`endif

endmodule

// ----- tb/dc_motor_command_latch_test.sv -----
// Self-checking testbench for dc_motor_command_latch: directed and random motor commands
// over several dead band settings, with bursty input and a stalling receiver.
// Depends on mcl_pkg and dc_motor_command_latch.
module dc_motor_command_latch_test;
    import mcl_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 52;

    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;
    localparam int STALL_HEAVY   = 3;

    localparam int BRIDGE_A_BIT [MOTORS] = '{2, 1, 5, 0};
    localparam int BRIDGE_B_BIT [MOTORS] = '{3, 4, 7, 6};

    typedef struct packed {
        logic [INDEX_W-1:0]        motor;
        logic signed [SPEED_W-1:0] speed;
    } t_motor_cmd;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [DUTY_W-1:0] duty;
        logic              bit_valid;
        logic              serial_bit;
        logic              last;
    } t_motor_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [DUTY_W-1:0]           i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [INDEX_W-1:0]          i_motor_index;
    logic signed [SPEED_W-1:0]   i_speed;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [CH_W-1:0]             o_pwm_channel;
    logic [DUTY_W-1:0]           o_duty;
    logic                        o_bit_valid;
    logic                        o_serial_bit;
    logic                        o_last;

    t_motor_cmd    cmd_pending[$];
    t_motor_result result_due[$];

    logic [DUTY_W-1:0]  dead_band_cfg;
    logic [LATCH_W-1:0] latch_byte;
    t_dir               motor_dir [MOTORS];

    bit in_taken;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_span;
    logic [7:0] stall_mask;

    int cycle_count;
    int n_errors;
    int n_taken;
    int n_results;
    int n_shifts;
    int n_settings;
    int db_plan [6];

    dc_motor_command_latch i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_motor_index (i_motor_index),
        .i_speed       (i_speed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pwm_channel (o_pwm_channel),
        .o_duty        (o_duty),
        .o_bit_valid   (o_bit_valid),
        .o_serial_bit  (o_serial_bit),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_command(input logic [INDEX_W-1:0] motor,
                                   input logic signed [SPEED_W-1:0] speed);
        int spd;
        int mag;
        int ch;
        t_dir dir;
        t_motor_result r;
        logic [LATCH_W-1:0] a_mask;
        logic [LATCH_W-1:0] b_mask;
        if (motor < 1 || motor > MOTORS)
            return;
        ch = motor - 1;
        spd = speed;
        if (spd > 255)
            spd = 255;
        else if (spd < -255)
            spd = -255;
        mag = (spd < 0) ? -spd : spd;
        if (mag < int'(dead_band_cfg))
            mag = mag + int'(dead_band_cfg);
        if (mag > 255)
            mag = 255;
        dir = (spd > 0) ? DIR_FWD : ((spd < 0) ? DIR_BACK : DIR_STOP);
        r.ch = CH_W'(ch);
        r.duty = DUTY_W'(mag);
        r.bit_valid = 1'b0;
        r.serial_bit = 1'b0;
        r.last = 1'b1;
        if (dir == motor_dir[ch]) begin
            result_due.push_back(r);
            return;
        end
        motor_dir[ch] = dir;
        a_mask = 8'd1 << BRIDGE_A_BIT[ch];
        b_mask = 8'd1 << BRIDGE_B_BIT[ch];
        case (dir)
            DIR_FWD:  latch_byte = (latch_byte | a_mask) & ~b_mask;
            DIR_BACK: latch_byte = (latch_byte & ~a_mask) | b_mask;
            default:  latch_byte = latch_byte & ~(a_mask | b_mask);
        endcase
        for (int k = 0; k < LATCH_W; k++) begin
            r.bit_valid = 1'b1;
            r.serial_bit = latch_byte[LATCH_W-1-k];
            r.last = (k == LATCH_W - 1);
            result_due.push_back(r);
        end
        n_shifts++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    function automatic logic signed [SPEED_W-1:0] rand_speed(input int db);
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, db + 2);
            2:    v = 0;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 255;
                    1: v = 256;
                    2: v = 1023;
                    default: v = 1024;
                endcase
            end
            4:    v = 1;
            default: v = $urandom_range(0, 1023);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        if (v > 1023)
            v = 1023;
        return v[SPEED_W-1:0];
    endfunction

    task automatic queue_cmd(input int motor, input int speed);
        t_motor_cmd c;
        c.motor = motor[INDEX_W-1:0];
        c.speed = speed[SPEED_W-1:0];
        cmd_pending.push_back(c);
    endtask

    task automatic queue_random(input int count);
        t_motor_cmd c;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 85)
                c.motor = INDEX_W'($urandom_range(1, MOTORS));
            else
                c.motor = $urandom_range(0, 1) ? INDEX_W'(0) : INDEX_W'($urandom_range(5, 7));
            c.speed = rand_speed(dead_band_cfg);
            cmd_pending.push_back(c);
        end
    endtask

    task automatic wait_drained;
        do begin
            @(posedge i_clk);
            #1;
        end while (cmd_pending.size() != 0 || (i_in_valid && !in_taken)
                   || result_due.size() != 0);
    endtask

    task automatic write_dead_band(input logic [DUTY_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        dead_band_cfg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        @(posedge i_clk);
    endtask

    // Sender: bursts of transactions separated by random gaps; hold while not taken.
    always @(negedge i_clk) begin
        t_motor_cmd c;
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (cmd_pending.size() != 0) begin
                c = cmd_pending.pop_front();
                i_in_valid <= 1'b1;
                i_motor_index <= c.motor;
                i_speed <= c.speed;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4:          gap_left = $urandom_range(10, 30);
                        default:    gap_left = $urandom_range(1, 6);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, switching to a new random mode at the end of each random-length span.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_span = $urandom_range(16, 96);
            stall_mask = 8'($urandom);
        end
        stall_span--;
        case (stall_mode)
            STALL_RANDOM:  i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: i_out_stall <= stall_mask[stall_span % 8];
            STALL_HEAVY:   i_out_stall <= ($urandom_range(0, 9) != 0);
            default:       i_out_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            predict_command(i_motor_index, i_speed);
            in_taken = 1'b1;
            n_taken++;
        end
    end

    always @(posedge i_clk) begin
        t_motor_result want;
        if (o_out_valid && !i_out_stall) begin
            if (result_due.size() == 0) begin
                $error("unexpected result: pwm_channel %0d duty %0d serial_bit %0d",
                       o_pwm_channel, o_duty, o_serial_bit);
                n_errors++;
            end else begin
                want = result_due.pop_front();
                check_field("pwm_channel", want.ch, o_pwm_channel);
                check_field("duty", want.duty, o_duty);
                check_field("bit_valid", want.bit_valid, o_bit_valid);
                check_field("serial_bit", want.serial_bit, o_serial_bit);
                check_field("last", want.last, o_last);
                n_results++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, result_due.size());
        $display("dc_motor_command_latch verification failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_motor_index = '0;
        i_speed = '0;
        i_out_stall = 1'b0;
        dead_band_cfg = '0;
        latch_byte = '0;
        foreach (motor_dir[m])
            motor_dir[m] = DIR_STOP;
        in_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_span = 0;
        cycle_count = 0;
        n_errors = 0;
        n_taken = 0;
        n_results = 0;
        n_shifts = 0;
        n_settings = 1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_cmd(1, 0);
        queue_cmd(1, 1);
        queue_cmd(1, 1023);
        queue_cmd(1, -1024);
        queue_cmd(1, -1);
        queue_cmd(2, 255);
        queue_cmd(2, 256);
        queue_cmd(2, -255);
        queue_cmd(2, -256);
        queue_cmd(3, 1);
        queue_cmd(3, -1);
        queue_cmd(3, 0);
        queue_cmd(4, 1023);
        queue_cmd(4, -1024);
        queue_cmd(4, 0);
        queue_cmd(0, 5);
        queue_cmd(5, -7);
        queue_cmd(6, 1023);
        queue_cmd(7, -1024);
        queue_cmd(1, 0);
        queue_cmd(2, 0);

        write_dead_band(8'd255);
        queue_cmd(1, 0);
        queue_cmd(2, 3);
        queue_cmd(3, -200);
        queue_cmd(4, 255);
        queue_random(PHASE_ITEMS);

        db_plan = '{0, 1, 40, 254, 128, 0};
        db_plan[5] = $urandom_range(2, 253);
        foreach (db_plan[p]) begin
            write_dead_band(db_plan[p][DUTY_W-1:0]);
            queue_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d commands taken over %0d dead band settings, %0d results checked",
                 n_taken, n_settings, n_results);
        $display("%0d of them shifted the latch byte out", n_shifts);
        if (n_errors == 0 && result_due.size() == 0)
            $display("dc_motor_command_latch verification clean");
        else
            $display("dc_motor_command_latch verification failed");
        $finish;
    end

endmodule
